// ----- rtl/core/assert_macros.svh -----
// Assertion macros for the text console writer RTL.
// Uses the clk and rst names of the module that includes this header.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define TCW_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is high
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/tcw_pkg.sv -----
// Shared types, sizes and codes for the text console writer.
// No dependencies; the front, queue, back and top RTL files refer to it by scoped names.
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROW_COUNT  = 25;
  localparam int CELL_COUNT = COLUMNS * ROW_COUNT;
  localparam int CELL_W     = 16;

  localparam int COL_W  = $clog2(COLUMNS);
  localparam int FILL_W = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROW_COUNT);
  localparam int ADDR_W = $clog2(CELL_COUNT);

  // Cell index width of the input word and the reciprocal used to split it
  localparam int IDX_W = 11;
  localparam int RECIP = (2 ** IDX_W) / COLUMNS;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [7:0] NEWLINE_CODE = 8'd10;
  localparam logic [7:0] ATTR_RESET   = 8'd7;

  // Input kinds
  localparam logic [1:0] KIND_PUT   = 2'd0;
  localparam logic [1:0] KIND_CLEAR = 2'd1;
  localparam logic [1:0] KIND_READ  = 2'd2;

  // Operations passed from front to back
  localparam logic [2:0] OP_NOP     = 3'd0;
  localparam logic [2:0] OP_PUT     = 3'd1;
  localparam logic [2:0] OP_NEWLINE = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_READ    = 3'd4;

  typedef struct packed {
    logic [1:0]       kind;
    logic [7:0]       char_code;
    logic [IDX_W-1:0] cell_index;
  } tcw_item_t;

  typedef struct packed {
    logic [6:0]  cursor_col;
    logic [4:0]  cursor_row;
    logic [15:0] cell_data;
    logic        scrolled;
  } tcw_result_t;

  typedef struct packed {
    logic [2:0]       op;
    logic [7:0]       code;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } tcw_cmd_t;

  typedef struct packed {
    logic     valid;
    tcw_cmd_t cmd;
  } tcw_cmd_flow_t;

endpackage

// ----- rtl/core/tcw_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/tcw_front.sv -----
// Front end: accepts input words, splits the read index into row and column,
// and classifies each word into a back-end operation. Uses tcw_pkg.
module tcw_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cmd_valid,
  output logic                   cmd_stall,
  input  tcw_pkg::tcw_item_t     cmd,
  output tcw_pkg::tcw_cmd_flow_t push,
  input  logic                   push_ready
);

  logic                      hold_valid;
  tcw_pkg::tcw_item_t        hold;
  logic [tcw_pkg::IDX_W-1:0] hold_q0;
  logic [2*tcw_pkg::IDX_W-1:0] prod;
  logic                      accept;
  logic [tcw_pkg::IDX_W-1:0] qc;
  logic [tcw_pkg::IDX_W-1:0] rem0;
  logic [tcw_pkg::IDX_W-1:0] rem;
  logic [tcw_pkg::IDX_W-1:0] quo;
  logic                      in_range;
  logic [2:0]                op;

  assign cmd_stall = hold_valid && !push_ready;
  assign accept    = cmd_valid && !cmd_stall;

  // Quotient estimate; at most one short of the true row
  assign prod = cmd.cell_index * tcw_pkg::IDX_W'(tcw_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (accept) begin
      hold_valid <= 1'b1;
    end else if (push_ready) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold    <= cmd;
      hold_q0 <= prod[2*tcw_pkg::IDX_W-1:tcw_pkg::IDX_W];
    end
  end

  always_comb begin
    qc   = tcw_pkg::IDX_W'(hold_q0 * tcw_pkg::COLUMNS);
    rem0 = hold.cell_index - qc;
    // Correct the estimate once
    if (rem0 >= tcw_pkg::IDX_W'(tcw_pkg::COLUMNS)) begin
      quo = hold_q0 + tcw_pkg::IDX_W'(1);
      rem = rem0 - tcw_pkg::IDX_W'(tcw_pkg::COLUMNS);
    end else begin
      quo = hold_q0;
      rem = rem0;
    end
    in_range = int'(hold.cell_index) < tcw_pkg::CELL_COUNT;
    case (hold.kind)
      tcw_pkg::KIND_PUT: begin
        op = (hold.char_code == tcw_pkg::NEWLINE_CODE) ? tcw_pkg::OP_NEWLINE
                                                       : tcw_pkg::OP_PUT;
      end
      tcw_pkg::KIND_CLEAR: begin
        op = tcw_pkg::OP_CLEAR;
      end
      tcw_pkg::KIND_READ: begin
        op = in_range ? tcw_pkg::OP_READ : tcw_pkg::OP_NOP;
      end
      default: begin
        op = tcw_pkg::OP_NOP;
      end
    endcase
  end

  assign push.valid    = hold_valid;
  assign push.cmd.op   = op;
  assign push.cmd.code = hold.char_code;
  assign push.cmd.row  = tcw_pkg::ROW_W'(quo);
  assign push.cmd.col  = tcw_pkg::COL_W'(rem);

endmodule

// ----- rtl/core/tcw_queue.sv -----
// Short command queue between the front and back ends.
// Uses tcw_pkg for the command type and depth.
module tcw_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  tcw_pkg::tcw_cmd_flow_t push,
  output logic                   push_ready,
  output tcw_pkg::tcw_cmd_flow_t pop,
  input  logic                   pop_en
);

  tcw_pkg::tcw_cmd_t          slots [tcw_pkg::QDEPTH];
  logic [tcw_pkg::QPTR_W-1:0] wr_ptr;
  logic [tcw_pkg::QPTR_W-1:0] rd_ptr;
  logic [tcw_pkg::QCNT_W-1:0] count;
  logic                       push_do;

  assign push_ready = count != tcw_pkg::QCNT_W'(tcw_pkg::QDEPTH);
  assign push_do    = push.valid && push_ready;
  assign pop.valid  = count != '0;
  assign pop.cmd    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_do) begin
        wr_ptr <= (wr_ptr == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0
                                                                   : wr_ptr + 1'b1;
      end
      if (pop_en) begin
        rd_ptr <= (rd_ptr == tcw_pkg::QPTR_W'(tcw_pkg::QDEPTH - 1)) ? '0
                                                                   : rd_ptr + 1'b1;
      end
      if (push_do && !pop_en) begin
        count <= count + 1'b1;
      end else if (pop_en && !push_do) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push_do) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

endmodule

// ----- rtl/core/tcw_back.sv -----
// Back end: cursor, scroll offset, per-row fill counts and the cell RAM.
// Executes queued operations and holds the result word. Uses tcw_pkg, tcw_ram.
module tcw_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [7:0]             cfg_data,
  input  tcw_pkg::tcw_cmd_flow_t pop,
  output logic                   pop_en,
  output logic                   rsp_valid,
  input  logic                   rsp_stall,
  output tcw_pkg::tcw_result_t   rsp
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic                       state;
  logic [tcw_pkg::COL_W-1:0]  cur_col;
  logic [tcw_pkg::ROW_W-1:0]  cur_row;
  logic [tcw_pkg::ROW_W-1:0]  cur_prow;
  logic [tcw_pkg::ROW_W-1:0]  base;
  logic [7:0]                 attr;
  logic [tcw_pkg::FILL_W-1:0] fill [tcw_pkg::ROW_COUNT];
  logic                       keep;

  logic [tcw_pkg::COL_W-1:0]  col_next;
  logic [tcw_pkg::ROW_W-1:0]  row_next;
  logic [tcw_pkg::ROW_W-1:0]  prow_next;
  logic [tcw_pkg::ROW_W-1:0]  base_next;
  logic [tcw_pkg::FILL_W-1:0] col_inc;
  logic [tcw_pkg::ROW_W-1:0]  prow_inc;
  logic [tcw_pkg::ROW_W-1:0]  base_inc;
  logic                       last_row;
  logic                       wrap;
  logic                       scroll;
  logic                       out_free;
  logic [2:0]                 op;
  logic [tcw_pkg::ROW_W:0]    rd_sum;
  logic [tcw_pkg::ROW_W-1:0]  rd_prow;
  logic [tcw_pkg::ADDR_W-1:0] raddr;
  logic [tcw_pkg::ADDR_W-1:0] waddr;
  logic                       we;
  logic [tcw_pkg::CELL_W-1:0] rdata;

  assign out_free = !rsp_valid || !rsp_stall;
  assign pop_en   = (state == ST_IDLE) && pop.valid && out_free;
  assign op       = pop.cmd.op;

  always_comb begin
    col_inc  = tcw_pkg::FILL_W'(cur_col) + tcw_pkg::FILL_W'(1);
    last_row = cur_row == tcw_pkg::ROW_W'(tcw_pkg::ROW_COUNT - 1);
    prow_inc = (cur_prow == tcw_pkg::ROW_W'(tcw_pkg::ROW_COUNT - 1)) ? '0
                                                                     : cur_prow + 1'b1;
    base_inc = (base == tcw_pkg::ROW_W'(tcw_pkg::ROW_COUNT - 1)) ? '0 : base + 1'b1;
    wrap     = (op == tcw_pkg::OP_NEWLINE) ||
               ((op == tcw_pkg::OP_PUT) && (col_inc == tcw_pkg::FILL_W'(tcw_pkg::COLUMNS)));
    scroll   = wrap && last_row;

    col_next  = cur_col;
    row_next  = cur_row;
    prow_next = cur_prow;
    base_next = base;
    if (op inside {tcw_pkg::OP_PUT, tcw_pkg::OP_NEWLINE}) begin
      col_next = wrap ? '0 : tcw_pkg::COL_W'(col_inc);
      if (wrap && !last_row) begin
        row_next  = cur_row + 1'b1;
        prow_next = prow_inc;
      end else if (scroll) begin
        // Old top physical row becomes the new bottom row
        prow_next = base;
        base_next = base_inc;
      end
    end else if (op == tcw_pkg::OP_CLEAR) begin
      col_next  = '0;
      row_next  = '0;
      prow_next = base;
    end
  end

  // Read address: rotate the logical row by the scroll offset
  always_comb begin
    rd_sum  = {1'b0, pop.cmd.row} + {1'b0, base};
    rd_prow = (rd_sum >= (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROW_COUNT))
              ? tcw_pkg::ROW_W'(rd_sum - (tcw_pkg::ROW_W + 1)'(tcw_pkg::ROW_COUNT))
              : tcw_pkg::ROW_W'(rd_sum);
    raddr   = tcw_pkg::ADDR_W'(rd_prow * tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(pop.cmd.col);
    waddr   = tcw_pkg::ADDR_W'(cur_prow * tcw_pkg::COLUMNS) + tcw_pkg::ADDR_W'(cur_col);
    we      = pop_en && (op == tcw_pkg::OP_PUT);
  end

  tcw_ram #(
    .WIDTH(tcw_pkg::CELL_W),
    .DEPTH(tcw_pkg::CELL_COUNT)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata({attr, pop.cmd.code}),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cur_col   <= '0;
      cur_row   <= '0;
      cur_prow  <= '0;
      base      <= '0;
      attr      <= tcw_pkg::ATTR_RESET;
      rsp_valid <= 1'b0;
      for (int i = 0; i < tcw_pkg::ROW_COUNT; i++) begin
        fill[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        attr <= cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (pop_en) begin
        if (op == tcw_pkg::OP_READ) begin
          state <= ST_READ;
        end else begin
          rsp_valid <= 1'b1;
        end
        cur_col  <= col_next;
        cur_row  <= row_next;
        cur_prow <= prow_next;
        base     <= base_next;
        if (op == tcw_pkg::OP_PUT) begin
          fill[cur_prow] <= col_inc;
        end
        // Blank the row that enters at the bottom
        if (scroll) begin
          fill[base] <= '0;
        end
        if (op == tcw_pkg::OP_CLEAR) begin
          for (int i = 0; i < tcw_pkg::ROW_COUNT; i++) begin
            fill[i] <= '0;
          end
        end
      end
      if (state == ST_READ) begin
        state     <= ST_IDLE;
        rsp_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop_en) begin
      // A cell past the row's written columns reads as zero
      keep <= tcw_pkg::FILL_W'(pop.cmd.col) < fill[rd_prow];
      if (op != tcw_pkg::OP_READ) begin
        rsp.cursor_col <= 7'(col_next);
        rsp.cursor_row <= 5'(row_next);
        rsp.cell_data  <= 16'd0;
        rsp.scrolled   <= scroll;
      end
    end
    if (state == ST_READ) begin
      rsp.cursor_col <= 7'(cur_col);
      rsp.cursor_row <= 5'(cur_row);
      rsp.cell_data  <= keep ? 16'(rdata) : 16'd0;
      rsp.scrolled   <= 1'b0;
    end
  end

endmodule

// ----- rtl/core/text_console_writer.sv -----
// Top level of the text console writer: front end, command queue, back end.
// Uses tcw_pkg, tcw_front, tcw_queue, tcw_back and assert_macros.svh.
//
//   channel  | handshake            | word
//   ---------+----------------------+-------------------------------------
//   cmd      | cmd_valid/cmd_stall  | kind, char_code, cell_index
//   rsp      | rsp_valid/rsp_stall  | cursor_col, cursor_row, cell_data, scrolled
//   cfg      | cfg_valid/cfg_ready  | text attribute byte (always ready)
//
// A word passes the front register and a queue slot before the result register.
// The back end takes a put, newline, scroll, clear or no-op straight to the result
// register and a read through ST_READ, for the cell RAM's registered read port.
// Scroll rotates a row offset and clear moves the cursor to it; both zero per-row fill counts: no sweep.
// Reset is synchronous; no clearing pass, unwritten cells read as zero.
// A stalled result holds the back end; the two-entry queue and the front
// register absorb input words until the input is stalled.
`include "assert_macros.svh"

module text_console_writer (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cmd_valid,
  output logic                 cmd_stall,
  input  tcw_pkg::tcw_item_t   cmd,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output tcw_pkg::tcw_result_t rsp,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  tcw_pkg::tcw_cmd_flow_t push;
  tcw_pkg::tcw_cmd_flow_t pop;
  logic                   push_ready;
  logic                   pop_en;

  assign cfg_ready = 1'b1;

  tcw_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .push      (push),
    .push_ready(push_ready)
  );

  tcw_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .pop       (pop),
    .pop_en    (pop_en)
  );

  tcw_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .pop      (pop),
    .pop_en   (pop_en),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  `TCW_ASSERT_IMPL(a_stall_needs_block, cmd_stall, push.valid && !push_ready, "input stalled without a blocked word")
  `TCW_ASSERT_NEXT(a_blocked_word_holds, push.valid && !push_ready, push.valid && $stable(push.cmd), "blocked queue word changed")
  `TCW_ASSERT_IMPL(a_pop_not_empty, pop_en, pop.valid, "pop from empty queue")
  `TCW_ASSERT_IMPL(a_cursor_in_range, rsp_valid, (int'(rsp.cursor_col) < tcw_pkg::COLUMNS) && (int'(rsp.cursor_row) < tcw_pkg::ROW_COUNT), "cursor out of range")

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for text_console_writer: drives command words, predicts each
// result word from its own screen image and compares field by field. Uses tcw_pkg and
// the text_console_writer RTL.
`timescale 1ns / 100ps

module tb_top;

  localparam logic [1:0] KIND_NOP  = 2'd3;
  localparam int         HOLD_LEN  = 160;
  localparam int         IDLE_PCT  = 29;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cmd_valid = 1'b0;
  logic                 cmd_stall;
  tcw_pkg::tcw_item_t   cmd       = '0;
  logic                 rsp_valid;
  logic                 rsp_stall = 1'b0;
  tcw_pkg::tcw_result_t rsp;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_data  = 8'd0;

  text_console_writer uut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Command words waiting to be sent, and results owed by the block
  tcw_pkg::tcw_item_t   cmd_backlog[$];
  tcw_pkg::tcw_result_t due_results[$];

  // Screen image kept by the testbench
  logic [15:0] screen_img[0:tcw_pkg::CELL_COUNT-1];
  int unsigned cur_c = 0;
  int unsigned cur_r = 0;
  logic [7:0]  attr_now = tcw_pkg::ATTR_RESET;

  logic        cmd_went = 1'b0;
  bit          quiet = 1'b0;
  int unsigned hold_req = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned n_checked = 0;
  int unsigned n_put = 0, n_wrap = 0, n_newline = 0, n_scroll = 0, n_clear = 0;
  int unsigned n_read = 0, n_read_oob = 0, n_nop = 0, n_cfg = 0;

  initial begin
    for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) screen_img[i] = 16'd0;
  end

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch %s: expected 0x%0h got 0x%0h at %0t", field, want, got, $time);
    errors++;
  endtask

  // Move to the start of the next row; scroll up and blank the bottom row past the last one
  function automatic bit next_line();
    cur_c = 0;
    cur_r++;
    if (cur_r >= tcw_pkg::ROW_COUNT) begin
      cur_r = tcw_pkg::ROW_COUNT - 1;
      for (int i = 0; i < tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i++)
        screen_img[i] = screen_img[i + tcw_pkg::COLUMNS];
      for (int i = tcw_pkg::CELL_COUNT - tcw_pkg::COLUMNS; i < tcw_pkg::CELL_COUNT; i++)
        screen_img[i] = 16'd0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic console_apply(input tcw_pkg::tcw_item_t it,
                               output tcw_pkg::tcw_result_t res);
    logic [15:0] data;
    bit          rolled;
    int unsigned pos;
    data   = 16'd0;
    rolled = 1'b0;
    case (it.kind)
      tcw_pkg::KIND_PUT: begin
        if (it.char_code == tcw_pkg::NEWLINE_CODE) begin
          rolled = next_line();
          n_newline++;
        end else begin
          pos = cur_r * tcw_pkg::COLUMNS + cur_c;
          screen_img[pos] = {attr_now, it.char_code};
          n_put++;
          cur_c++;
          if (cur_c >= tcw_pkg::COLUMNS) begin
            rolled = next_line();
            n_wrap++;
          end
        end
      end
      tcw_pkg::KIND_CLEAR: begin
        for (int i = 0; i < tcw_pkg::CELL_COUNT; i++) screen_img[i] = 16'd0;
        cur_c = 0;
        cur_r = 0;
        n_clear++;
      end
      tcw_pkg::KIND_READ: begin
        n_read++;
        if (int'(it.cell_index) < tcw_pkg::CELL_COUNT) data = screen_img[it.cell_index];
        else n_read_oob++;
      end
      default: n_nop++;
    endcase
    if (rolled) n_scroll++;
    res.cursor_col = cur_c[6:0];
    res.cursor_row = cur_r[4:0];
    res.cell_data  = data;
    res.scrolled   = rolled;
  endtask

  // Sample both channels at the rising edge: check results, then predict accepted words
  always @(posedge clk) begin : watch
    tcw_pkg::tcw_result_t want;
    cmd_went <= cmd_valid && !cmd_stall;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result word", 0, 32'(rsp));
        end else begin
          want = due_results.pop_front();
          n_checked++;
          if (rsp.cursor_col !== want.cursor_col)
            report_mismatch("cursor_col", 32'(want.cursor_col), 32'(rsp.cursor_col));
          if (rsp.cursor_row !== want.cursor_row)
            report_mismatch("cursor_row", 32'(want.cursor_row), 32'(rsp.cursor_row));
          if (rsp.cell_data !== want.cell_data)
            report_mismatch("cell_data", 32'(want.cell_data), 32'(rsp.cell_data));
          if (rsp.scrolled !== want.scrolled)
            report_mismatch("scrolled", 32'(want.scrolled), 32'(rsp.scrolled));
        end
      end
      if (cfg_valid && cfg_ready) begin
        attr_now = cfg_data;
        n_cfg++;
      end
      if (cmd_valid && !cmd_stall) begin
        console_apply(cmd, want);
        due_results.push_back(want);
      end
    end
  end

  // Sender: load the next word once the current one is taken, idling at random
  always @(negedge clk) begin : cmd_drive
    logic next_valid;
    next_valid = cmd_valid;
    if (!rst && (!cmd_valid || cmd_went)) begin
      next_valid = 1'b0;
      if (cmd_backlog.size() > 0 && (quiet || $urandom_range(0, 99) >= IDLE_PCT)) begin
        cmd <= cmd_backlog.pop_front();
        next_valid = 1'b1;
      end
    end
    cmd_valid <= next_valid;
  end

  // Receiver: random stalls, plus a long hold-off on request
  always @(negedge clk) begin : rsp_drive
    if (hold_left > 0) begin
      rsp_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_LEN;
      rsp_stall <= 1'b1;
    end else begin
      rsp_stall <= !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    end
  end

  task automatic queue_word(input logic [1:0] kind, input logic [7:0] code,
                            input logic [10:0] idx);
    tcw_pkg::tcw_item_t it;
    it.kind       = kind;
    it.char_code  = code;
    it.cell_index = idx;
    cmd_backlog.push_back(it);
  endtask

  // Queue random words; the mix is given in parts per thousand
  task automatic queue_random(input int count, input int nl_pm, input int clr_pm,
                              input int rd_pm, input int nop_pm);
    tcw_pkg::tcw_item_t it;
    int                 pick;
    for (int n = 0; n < count; n++) begin
      it.char_code  = 8'($urandom_range(0, 255));
      it.cell_index = 11'($urandom_range(0, 2047));
      pick = $urandom_range(0, 999);
      if (pick < clr_pm) begin
        it.kind = tcw_pkg::KIND_CLEAR;
      end else if (pick < clr_pm + nop_pm) begin
        it.kind = KIND_NOP;
      end else if (pick < clr_pm + nop_pm + rd_pm) begin
        it.kind = tcw_pkg::KIND_READ;
        pick = $urandom_range(0, 99);
        // favor the left part of rows, where short lines leave text
        if (pick < 35)
          it.cell_index = 11'($urandom_range(0, tcw_pkg::ROW_COUNT - 1) * tcw_pkg::COLUMNS
                              + $urandom_range(0, 15));
        else if (pick < 60)
          it.cell_index = 11'($urandom_range(0, tcw_pkg::CELL_COUNT - 1));
        else if (pick < 80)
          it.cell_index = 11'($urandom_range(tcw_pkg::CELL_COUNT, 2047));
      end else begin
        it.kind = tcw_pkg::KIND_PUT;
        if ($urandom_range(0, 999) < nl_pm) it.char_code = tcw_pkg::NEWLINE_CODE;
      end
      cmd_backlog.push_back(it);
    end
  endtask

  // Wait until every word is sent and answered, then let the back end settle
  task automatic drain_all();
    while (cmd_backlog.size() != 0 || cmd_valid || due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_attr(input logic [7:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: every kind, field extremes, range edges of reads
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd0);
    queue_word(tcw_pkg::KIND_PUT,   8'h41, 11'd0);
    queue_word(tcw_pkg::KIND_PUT,   8'h00, 11'd2047);
    queue_word(tcw_pkg::KIND_PUT,   8'hFF, 11'd0);
    queue_word(tcw_pkg::KIND_READ,  8'hFF, 11'd0);
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd1);
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd2);
    queue_word(tcw_pkg::KIND_PUT,   tcw_pkg::NEWLINE_CODE, 11'd0);
    queue_word(tcw_pkg::KIND_PUT,   8'h55, 11'd0);
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd80);
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd1999);
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd2000);
    queue_word(tcw_pkg::KIND_READ,  8'hFF, 11'd2047);
    queue_word(KIND_NOP,            8'hFF, 11'd2047);
    queue_word(tcw_pkg::KIND_PUT,   8'hAA, 11'd0);
    queue_word(tcw_pkg::KIND_CLEAR, 8'h41, 11'd1234);
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd0);
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd80);
    queue_word(tcw_pkg::KIND_PUT,   tcw_pkg::NEWLINE_CODE, 11'd2047);
    queue_word(tcw_pkg::KIND_PUT,   8'h7F, 11'd0);
    queue_word(tcw_pkg::KIND_READ,  8'h00, 11'd80);
    queue_word(KIND_NOP,            8'h00, 11'd0);
    drain_all();
    write_attr(8'hFF);

    // Many short lines: reach the bottom row and scroll often
    queue_random(350, 350, 5, 250, 20);
    drain_all();
    write_attr(8'h00);

    // Long lines with no idling: wrap at the last column, also on the bottom row
    quiet = 1'b1;
    queue_random(500, 10, 0, 200, 20);
    drain_all();
    quiet = 1'b0;
    write_attr(8'($urandom_range(0, 255)));

    // Mixed traffic while the receiver holds off long enough to back up the input
    queue_random(450, 120, 10, 250, 20);
    @(posedge clk);
    hold_req++;
    drain_all();
    write_attr(8'($urandom_range(1, 254)));

    queue_random(430, 120, 10, 250, 20);
    drain_all();
    repeat (8) @(posedge clk);

    $display("covered %0d characters (%0d line wraps), %0d newlines, %0d scrolls, %0d clears",
             n_put, n_wrap, n_newline, n_scroll, n_clear);
    $display("and %0d reads (%0d out of range), %0d no-ops, %0d attribute writes; %0d checked",
             n_read, n_read_oob, n_nop, n_cfg, n_checked);
    if (errors == 0 && due_results.size() == 0) begin
      $display("PASS text_console_writer");
    end else begin
      $display("FAIL text_console_writer");
    end
    $finish;
  end

  initial begin : run_limit
    #4_000_000;
    $display("timeout with %0d results still due", due_results.size());
    $display("FAIL text_console_writer");
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/tcw_pkg.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_front.sv
rtl/core/tcw_queue.sv
rtl/core/tcw_back.sv
rtl/core/text_console_writer.sv
tb/sv/tb_top.sv
